// ===== rtl/core/lrupr_pkg.sv =====
`default_nettype none

package lrupr_pkg;

  // Build-time defaults
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed field widths of the channels
  localparam int PAGE_NUM_W = 16;
  localparam int COUNT_W    = 4;
  localparam int FAULT_W    = 32;
  localparam int CFG_W      = 4;

  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = 4'd8;
  localparam logic [FAULT_W-1:0] FAULT_MAX         = '1;

  typedef struct packed {
    logic [PAGE_NUM_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic                  page_fault;
    logic                  evicted_valid;
    logic [PAGE_NUM_W-1:0] evicted_page;
    logic [COUNT_W-1:0]    resident_count;
    logic [FAULT_W-1:0]    fault_total;
  } res_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic take;   // a request is accepted this cycle
    logic evict;  // miss with full frames: whole list moves down by one
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lrupr_stream_if.sv =====
`default_nettype none

interface lrupr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lrupr_cell.sv =====
`default_nettype none

module lrupr_cell #(
  parameter int PAGE_BITS = 16,
  parameter int OCC_W     = 4,
  parameter int INDEX     = 0
) (
  input  wire logic                    clk,
  input  wire lrupr_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [OCC_W-1:0]        occ_i,
  input  wire logic [OCC_W-1:0]        append_pos_i,
  input  wire logic [PAGE_BITS-1:0]    page_i,
  input  wire logic [PAGE_BITS-1:0]    right_page_i,
  input  wire logic                    hit_seen_i,
  output logic                         hit_seen_o,
  output logic [PAGE_BITS-1:0]         page_o
);
  import lrupr_pkg::*;

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_nxt;
  logic                 occupied;
  logic                 hit_here;

  assign occupied   = OCC_W'(INDEX) < occ_i;
  assign hit_here   = occupied && (page_r == page_i);
  // hit at or below this position: close the gap by taking the neighbour's page
  assign hit_seen_o = hit_seen_i | hit_here;
  assign page_o     = page_r;

  always_comb begin
    page_nxt = page_r;
    if (ctrl_i.take) begin
      if (append_pos_i == OCC_W'(INDEX)) begin
        page_nxt = page_i;
      end else if (hit_seen_o || ctrl_i.evict) begin
        page_nxt = right_page_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_replacement_core.sv =====
`default_nettype none

// Channel   Dir  Payload                                      Handshake
// in_req    in   page_number                                  valid/ready
// out_res   out  page_fault, evicted_valid, evicted_page,     valid/ready
//                resident_count, fault_total
// cfg       in   frames_in_use                                cfg_wr_en, no stall
//
// One request per cycle while the output register is free or draining:
// every cell compares its page in parallel, the chain shifts by one
// position in the same cycle and the result is registered. Reset (rst_n
// low, synchronous) empties the list, clears the fault count and sets
// frames_in_use to 8. A stalled result holds in the output register; a
// new request is taken when that register is empty or is being drained.

module lru_page_replacement_core #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  lrupr_stream_if.sink                      in_req,
  lrupr_stream_if.source                    out_res,
  input  wire logic                         cfg_wr_en,
  input  wire logic [lrupr_pkg::CFG_W-1:0]  cfg_wr_data
);
  import lrupr_pkg::*;

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  // configuration
  logic [CFG_W-1:0]   frames_in_use_r;
  logic [LIM_W-1:0]   cfg_ext;
  logic [LIM_W-1:0]   occ_ext;
  logic [LIM_W-1:0]   lim;

  // list control
  logic [OCC_W-1:0]   occ_r;
  logic [OCC_W-1:0]   occ_nxt;
  logic [OCC_W-1:0]   append_pos;
  logic [FAULT_W-1:0] fault_r;
  logic [FAULT_W-1:0] fault_nxt;
  logic               take;
  logic               hit;
  logic               evict;
  cell_ctrl_t         ctrl;
  logic [PAGE_BITS-1:0] page_in;

  // chain
  logic [PAGE_BITS-1:0] cell_page [FRAMES];
  logic [FRAMES:0]      hit_chain;

  // result register
  logic out_valid_r;
  logic out_valid_nxt;
  res_t res_r;
  res_t res_nxt;

  // Accept while the result register is free or draining
  assign take         = in_req.valid && in_req.ready;
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign page_in      = PAGE_BITS'(in_req.payload.page_number);

  // Clamp the frame limit: zero acts as one, above the build acts as FRAMES
  assign cfg_ext = LIM_W'(frames_in_use_r);
  assign occ_ext = LIM_W'(occ_r);
  always_comb begin
    lim = cfg_ext;
    if (cfg_ext == '0) begin
      lim = LIM_W'(1);
    end else if (cfg_ext > LIM_W'(FRAMES)) begin
      lim = LIM_W'(FRAMES);
    end
  end

  assign hit   = hit_chain[FRAMES];
  assign evict = !hit && (occ_ext >= lim) && (occ_r != '0);

  // hit and eviction both free one place below the top, so the new page
  // lands on the last occupied position; otherwise it goes just above
  assign append_pos = (hit || evict) ? occ_r - OCC_W'(1) : occ_r;
  assign occ_nxt    = (hit || evict) ? occ_r : occ_r + OCC_W'(1);
  assign fault_nxt  = (!hit && fault_r != FAULT_MAX) ? fault_r + FAULT_W'(1) : fault_r;

  assign ctrl.take  = take;
  assign ctrl.evict = evict;

  assign hit_chain[0] = 1'b0;

  // Row of cells: entry 0 is least recently used
  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    logic [PAGE_BITS-1:0] right_page;
    if (k == FRAMES - 1) begin : g_last
      assign right_page = '0;
    end else begin : g_mid
      assign right_page = cell_page[k+1];
    end

    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .OCC_W     (OCC_W),
      .INDEX     (k)
    ) u_cell (
      .clk          (clk),
      .ctrl_i       (ctrl),
      .occ_i        (occ_r),
      .append_pos_i (append_pos),
      .page_i       (page_in),
      .right_page_i (right_page),
      .hit_seen_i   (hit_chain[k]),
      .hit_seen_o   (hit_chain[k+1]),
      .page_o       (cell_page[k])
    );
  end

  // Build the result; drop it from the register once taken
  always_comb begin
    res_nxt                = res_r;
    out_valid_nxt          = out_valid_r && !out_res.ready;
    if (take) begin
      out_valid_nxt          = 1'b1;
      res_nxt.page_fault     = !hit;
      res_nxt.evicted_valid  = evict;
      res_nxt.evicted_page   = evict ? PAGE_NUM_W'(cell_page[0]) : '0;
      res_nxt.resident_count = COUNT_W'(occ_nxt);
      res_nxt.fault_total    = fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= FRAMES_IN_USE_RST;
      occ_r           <= '0;
      fault_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frames_in_use_r <= cfg_wr_data;
      end
      if (take) begin
        occ_r   <= occ_nxt;
        fault_r <= fault_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.payload = res_r;

endmodule

`default_nettype wire
